// ----- sv/gtrd_pkg.sv -----
// gtrd_pkg: shared types and constants for the gap tolerant run detector
// holds the register map, field widths and reset values of the control registers
// no dependencies
`default_nettype none

package gtrd_pkg;

   // control register bus
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // fixed field widths
   localparam int SAMPLE_W    = 32;
   localparam int COUNT_W     = 17;
   localparam int GAP_W       = 8;
   localparam int GAP_LEN_W   = 9;
   localparam int START_IDX_W = 16;

   // largest run count
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_THRESHOLD   = 2'd0,
      REG_MIN_POINTS  = 2'd1,
      REG_MAX_GAP     = 2'd2,
      REG_START_INDEX = 2'd3
   } reg_index_type;

   // register reset values
   localparam logic [SAMPLE_W-1:0]    THRESHOLD_RESET   = '0;
   localparam logic [COUNT_W-1:0]     MIN_POINTS_RESET  = 17'd3;
   localparam logic [GAP_W-1:0]       MAX_GAP_RESET     = 8'd1;
   localparam logic [START_IDX_W-1:0] START_INDEX_RESET = '0;

endpackage

`default_nettype wire

// ----- sv/gap_tolerant_run_detector_unit.sv -----
// the response to a request is loaded into the response register at the clock edge that accepts the request
// throughput: one request per cycle while the response is not stalled; the run count / gap update is a recurrence
// in one register stage, and the response register lets a new request in while it is taken
// reset (synchronous, active high): run state cleared, no vector open, registers at defaults
// gap_tolerant_run_detector_unit: top level, control registers, run tracker and response register
// depends on gtrd_pkg
`default_nettype none

module gap_tolerant_run_detector_unit
   import gtrd_pkg::*;
#(
   parameter int INDEX_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [SAMPLE_W-1:0]   req_sample,
   input  wire logic                         req_last,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_count_reached,
   output logic                              rsp_run_found,
   output logic [INDEX_BITS-1:0]             rsp_run_first,
   output logic [INDEX_BITS-1:0]             rsp_run_final,
   // control register port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]             csr_prdata,
   output logic                              csr_pready
);

   localparam int SPAN_W = ((INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W) + 2;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   // control registers
   logic signed [SAMPLE_W-1:0] threshold_ff;
   logic [COUNT_W-1:0]         min_points_ff;
   logic [GAP_W-1:0]           max_gap_ff;
   logic [START_IDX_W-1:0]     start_index_ff;

   // run state
   logic [COUNT_W-1:0]    run_count_ff,  run_count_in;
   logic [GAP_LEN_W-1:0]  gap_len_ff,    gap_len_in;
   logic [GAP_LEN_W-1:0]  prev_gap_ff,   prev_gap_in;
   logic [INDEX_BITS-1:0] span_first_ff, span_first_in;
   logic [INDEX_BITS-1:0] span_final_ff, span_final_in;
   logic [INDEX_BITS-1:0] position_ff,   position_in;
   logic                  in_vector_ff,  in_vector_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  reached_ff,  reached_in;
   logic                  found_ff,    found_in;
   logic [INDEX_BITS-1:0] first_ff,    first_in;
   logic [INDEX_BITS-1:0] final_ff,    final_in;

   logic                  csr_write;
   reg_index_type         csr_index;
   logic                  req_take;
   logic [47:0]           start_wide;
   logic [INDEX_BITS-1:0] start_idx;
   logic [INDEX_BITS-1:0] idx;
   logic                  sample_high;
   logic [COUNT_W-1:0]    count_inc;
   logic [GAP_LEN_W-1:0]  gap_plus;
   logic [COUNT_W:0]      penalty_sum;
   logic [COUNT_W:0]      penalty_diff;
   logic [SPAN_W-1:0]     span_len;

   assign csr_index = reg_index_type'(csr_paddr[3:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         min_points_ff  <= MIN_POINTS_RESET;
         max_gap_ff     <= MAX_GAP_RESET;
         start_index_ff <= START_INDEX_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD:   threshold_ff   <= csr_pwdata;
            REG_MIN_POINTS:  min_points_ff  <= csr_pwdata[COUNT_W-1:0];
            REG_MAX_GAP:     max_gap_ff     <= csr_pwdata[GAP_W-1:0];
            REG_START_INDEX: start_index_ff <= csr_pwdata[START_IDX_W-1:0];
            default:         ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         REG_THRESHOLD:   csr_prdata = threshold_ff;
         REG_MIN_POINTS:  csr_prdata = CSR_DATA_W'(min_points_ff);
         REG_MAX_GAP:     csr_prdata = CSR_DATA_W'(max_gap_ff);
         REG_START_INDEX: csr_prdata = CSR_DATA_W'(start_index_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // handshake: response register frees up when it is empty or being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // start index fitted to the index width
   assign start_wide = {32'd0, start_index_ff};
   assign start_idx  = start_wide[INDEX_BITS-1:0];

   // per-sample run update
   always_comb begin
      idx          = in_vector_ff ? position_ff : start_idx;
      sample_high  = req_sample > threshold_ff;
      count_inc    = (run_count_ff == COUNT_MAX) ? run_count_ff : run_count_ff + 1'b1;
      gap_plus     = gap_len_ff + 1'b1;
      penalty_sum  = {1'b0, run_count_ff} + 1'b1;
      penalty_diff = penalty_sum - (COUNT_W + 1)'(gap_plus);

      run_count_in  = run_count_ff;
      gap_len_in    = gap_len_ff;
      prev_gap_in   = prev_gap_ff;
      span_first_in = span_first_ff;
      span_final_in = span_final_ff;

      if (sample_high) begin
         run_count_in = count_inc;
         gap_len_in   = '0;
         prev_gap_in  = '0;
         if (count_inc == COUNT_W'(1)) begin
            span_first_in = idx;
         end else begin
            span_final_in = idx;
         end
      end else if (run_count_ff == '0 || gap_plus > {1'b0, max_gap_ff}) begin
         // no run open, or gap too long: run dropped
         run_count_in = '0;
         gap_len_in   = '0;
         prev_gap_in  = '0;
      end else if (gap_len_ff < {1'b0, max_gap_ff}) begin
         // tolerated gap sample still counts
         run_count_in = count_inc;
         gap_len_in   = gap_plus;
         prev_gap_in  = gap_len_ff;
      end else begin
         // penalty: count minus gap plus one, floored at zero
         run_count_in = (penalty_sum > (COUNT_W + 1)'(gap_plus)) ?
                        penalty_diff[COUNT_W-1:0] : '0;
         gap_len_in   = gap_plus;
         prev_gap_in  = '0;
      end

      // span report on run close or end of vector, if the span holds at least min_points indices
      span_len = SPAN_W'(span_final_in) - SPAN_W'(span_first_in) + SPAN_W'(1);
      found_in = 1'b0;
      first_in = '0;
      final_in = '0;
      if ((run_count_in == '0 || req_last) &&
          $signed(span_len) >= $signed(SPAN_W'(min_points_ff))) begin
         found_in      = 1'b1;
         first_in      = span_first_in;
         final_in      = span_final_in;
         span_first_in = '0;
         span_final_in = '0;
      end
      reached_in = run_count_in >= min_points_ff;

      // vector boundary and index advance
      if (req_last) begin
         run_count_in  = '0;
         gap_len_in    = '0;
         prev_gap_in   = '0;
         span_first_in = '0;
         span_final_in = '0;
         position_in   = start_idx;
         in_vector_in  = 1'b0;
      end else begin
         position_in  = (idx == INDEX_MAX) ? idx : idx + 1'b1;
         in_vector_in = 1'b1;
      end
   end

   // run state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff  <= '0;
         gap_len_ff    <= '0;
         prev_gap_ff   <= '0;
         span_first_ff <= '0;
         span_final_ff <= '0;
         position_ff   <= start_idx;
         in_vector_ff  <= 1'b0;
      end else if (req_take) begin
         run_count_ff  <= run_count_in;
         gap_len_ff    <= gap_len_in;
         prev_gap_ff   <= prev_gap_in;
         span_first_ff <= span_first_in;
         span_final_ff <= span_final_in;
         position_ff   <= position_in;
         in_vector_ff  <= in_vector_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         reached_ff <= reached_in;
         found_ff   <= found_in;
         first_ff   <= first_in;
         final_ff   <= final_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_count_reached = reached_ff;
   assign rsp_run_found     = found_ff;
   assign rsp_run_first     = first_ff;
   assign rsp_run_final     = final_ff;

endmodule

`default_nettype wire

// ----- sv/gtrd_checker.sv -----
// gtrd_checker: port-level assertions for the gap tolerant run detector, and its bind
// depends on gtrd_pkg and gap_tolerant_run_detector_unit
`default_nettype none

module gtrd_checker
   import gtrd_pkg::*;
#(
   parameter int INDEX_BITS = 16
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_count_reached,
   input wire logic                       rsp_run_found,
   input wire logic [INDEX_BITS-1:0]      rsp_run_first,
   input wire logic [INDEX_BITS-1:0]      rsp_run_final
);

   // a stalled response keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_reached) &&
      $stable(rsp_run_found) && $stable(rsp_run_first) && $stable(rsp_run_final))
      else $error("stalled response changed");

   // no span reported means both span indices read zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_found |-> rsp_run_first == '0 && rsp_run_final == '0)
      else $error("span indices set without a reported span");

   // requests are held back only by a full, stalled response register
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request blocked without a pending response");

   // no response comes out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind gap_tolerant_run_detector_unit gtrd_checker #(.INDEX_BITS(INDEX_BITS)) u_gtrd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_count_reached (rsp_count_reached),
   .rsp_run_found     (rsp_run_found),
   .rsp_run_first     (rsp_run_first),
   .rsp_run_final     (rsp_run_final)
);

`default_nettype wire
